// ----- src/krnkq_pkg.sv -----
// ----------------------------------------------------------------------------
// krnkq_pkg
// Shared types, constants and helpers of the keyboard report key queue.
// ----------------------------------------------------------------------------
package krnkq_pkg;

  localparam int unsigned RingSize = 8;
  localparam int unsigned KeySlots = 6;
  localparam int unsigned IdxW     = $clog2(RingSize);
  localparam int unsigned PosW     = $clog2(KeySlots + 1);
  localparam int unsigned SumW     = ((IdxW > PosW) ? IdxW : PosW) + 1;

  localparam logic [7:0] LastErrorCode = 8'h03;
  localparam logic [7:0] NoKey         = 8'h00;

  typedef enum logic {
    CmdReport = 1'b0,
    CmdPop    = 1'b1
  } cmd_e;

  typedef logic [7:0]            code_t;
  typedef logic [KeySlots*8-1:0] keys_t;
  typedef logic [IdxW-1:0]       idx_t;
  typedef logic [PosW-1:0]       pos_t;

  typedef struct packed {
    logic [KeySlots-1:0]            push;
    logic [KeySlots-1:0][7:0]       codes;
    logic                           all_err;
  } scan_t;

  typedef struct packed {
    logic empty;
    idx_t level;
  } ring_status_t;

  // wrap-around add, valid for n below RingSize
  function automatic idx_t ring_add(idx_t idx, pos_t n);
    logic [SumW-1:0] sum;
    sum = SumW'(idx) + SumW'(n);
    if (sum >= SumW'(RingSize)) begin
      sum = sum - SumW'(RingSize);
    end
    return sum[IdxW-1:0];
  endfunction

endpackage

// ----- src/krnkq_if.sv -----
// ----------------------------------------------------------------------------
// krnkq_req_if / krnkq_rsp_if
// Valid/ready channels of the keyboard report key queue.
// ----------------------------------------------------------------------------
interface krnkq_req_if;
  logic                  valid;
  logic                  ready;
  logic                  command;
  krnkq_pkg::keys_t      report_keys;
  krnkq_pkg::keys_t      previous_keys;

  modport source (output valid, command, report_keys, previous_keys, input ready);
  modport sink   (input valid, command, report_keys, previous_keys, output ready);
endinterface

interface krnkq_rsp_if;
  logic                  valid;
  logic                  ready;
  logic                  report_ok;
  logic                  key_valid;
  krnkq_pkg::code_t      key_out;

  modport source (output valid, report_ok, key_valid, key_out, input ready);
  modport sink   (input valid, report_ok, key_valid, key_out, output ready);
endinterface

// ----- src/krnkq_slot_scan.sv -----
// ----------------------------------------------------------------------------
// krnkq_slot_scan
// Finds the new key codes of a report and checks for an all-error report.
// ----------------------------------------------------------------------------
module krnkq_slot_scan (
  input  krnkq_pkg::keys_t  report_keys_i,
  input  krnkq_pkg::keys_t  previous_keys_i,
  output krnkq_pkg::scan_t  scan_o
);
  import krnkq_pkg::*;

  always_comb begin
    code_t cur;
    logic  seen;
    scan_o.all_err = 1'b1;
    for (int i = 0; i < KeySlots; i++) begin
      cur  = report_keys_i[i*8 +: 8];
      seen = 1'b0;
      for (int j = 0; j < KeySlots; j++) begin
        if (previous_keys_i[j*8 +: 8] == cur) begin
          seen = 1'b1;
        end
      end
      scan_o.codes[i] = cur;
      scan_o.push[i]  = (cur > LastErrorCode) && !seen;
      if (!(cur inside {[8'd1:LastErrorCode]})) begin
        scan_o.all_err = 1'b0;
      end
    end
  end

endmodule

// ----- src/krnkq_ring.sv -----
// ----------------------------------------------------------------------------
// krnkq_ring
// Key ring with read and write pointers; several pushes or one pop a step.
// ----------------------------------------------------------------------------
module krnkq_ring (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic                    pop_i,
  input  krnkq_pkg::scan_t        scan_i,
  output logic                    key_valid_o,
  output krnkq_pkg::code_t        key_out_o,
  output krnkq_pkg::ring_status_t status_o
);
  import krnkq_pkg::*;

  code_t           ring_q [RingSize];
  idx_t            wr_q, wr_d;
  idx_t            rd_q, rd_d;
  logic [SumW-1:0] level;
  logic [SumW-1:0] free;
  idx_t            addr    [KeySlots];
  logic [KeySlots-1:0] push_ok;
  pos_t            npush;

  always_comb begin
    if (wr_q >= rd_q) begin
      level = SumW'(wr_q) - SumW'(rd_q);
    end else begin
      level = SumW'(wr_q) + SumW'(RingSize) - SumW'(rd_q);
    end
    free = SumW'(RingSize - 1) - level;
  end

  // each new code takes the next place after those before it in slot order
  always_comb begin
    pos_t acc;
    acc   = '0;
    npush = '0;
    for (int i = 0; i < KeySlots; i++) begin
      push_ok[i] = scan_i.push[i] && (SumW'(acc) < free);
      addr[i]    = ring_add(wr_q, acc);
      acc        = acc + pos_t'(scan_i.push[i]);
      npush      = npush + pos_t'(push_ok[i]);
    end
  end

  assign status_o.empty = (wr_q == rd_q);
  assign status_o.level = level[IdxW-1:0];

  always_comb begin
    wr_d        = wr_q;
    rd_d        = rd_q;
    key_valid_o = 1'b0;
    key_out_o   = NoKey;
    if (pop_i) begin
      if (!status_o.empty) begin
        key_valid_o = 1'b1;
        key_out_o   = ring_q[rd_q];
        rd_d        = ring_add(rd_q, pos_t'(1));
      end
    end else begin
      wr_d = ring_add(wr_q, npush);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else if (step_i) begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && !pop_i) begin
      for (int i = 0; i < KeySlots; i++) begin
        if (push_ok[i]) begin
          ring_q[addr[i]] <= scan_i.codes[i];
        end
      end
    end
  end

endmodule

// ----- src/keyboard_report_new_key_queue.sv -----
// ----------------------------------------------------------------------------
// keyboard_report_new_key_queue
// Boot-keyboard report key queue: pushes newly pressed keys, pops them in order.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. A transfer is registered on input,
// then the slot scan and the ring update run combinationally into an output
// register, so the block takes one item per cycle while the output side does
// not stall, and answers from that output register. A report
// pushes each of its codes above 3 that is missing from the previous report,
// in slot order; pushes beyond the ring's free space (one entry always kept
// empty) are dropped. report_ok is low only when all six slots hold codes
// 1 to 3. A pop on an empty ring returns key_valid low and key code 0.
module keyboard_report_new_key_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  krnkq_req_if.sink   req_i,
  krnkq_rsp_if.source rsp_o
);
  import krnkq_pkg::*;

  logic         in_valid_q;
  logic         cmd_q;
  keys_t        report_q;
  keys_t        previous_q;
  logic         out_valid_q;
  logic         ok_q;
  logic         key_valid_q;
  code_t        key_q;
  logic         advance;
  logic         pop;
  scan_t        scan;
  logic         key_valid;
  code_t        key_out;
  ring_status_t status;

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign pop         = (cmd_q == CmdPop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      cmd_q      <= req_i.command;
      report_q   <= req_i.report_keys;
      previous_q <= req_i.previous_keys;
    end
    if (advance) begin
      ok_q        <= pop || !scan.all_err;
      key_valid_q <= key_valid;
      key_q       <= key_out;
    end
  end

  krnkq_slot_scan u_scan (
    .report_keys_i   (report_q),
    .previous_keys_i (previous_q),
    .scan_o          (scan)
  );

  krnkq_ring u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .pop_i       (pop),
    .scan_i      (scan),
    .key_valid_o (key_valid),
    .key_out_o   (key_out),
    .status_o    (status)
  );

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.report_ok = ok_q;
  assign rsp_o.key_valid = key_valid_q;
  assign rsp_o.key_out   = key_q;

  // one ring entry always stays unused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.level <= IdxW'(RingSize - 1))
    else $error("ring level beyond capacity");

  // only codes above the error range ever enter the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && key_valid_q |-> (key_q > LastErrorCode) && ok_q)
    else $error("popped key code in error range");

  // a pop on an empty ring returns nothing and leaves the ring empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && pop && status.empty |=> !key_valid_q && status.empty)
    else $error("pop on empty ring returned a key");

  // a report never shortens the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !pop |=> status.level >= $past(status.level))
    else $error("report removed queued keys");

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyboard report key queue. A directed table of
// reports and pops comes first, then about 1200 random pops and reports, the
// reports mostly chained ones whose previous keys are the last report sent. Each transfer in is
// run through a local model of the ring, and each transfer out is compared
// with the oldest expected result, under two patterns of random stalls and one run without stalls.
// ----------------------------------------------------------------------------
module tb;
  import krnkq_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned PhaseItems = 400;

  typedef struct packed {
    logic  report_ok;
    logic  key_valid;
    code_t key_out;
  } key_result_t;

  typedef struct {
    cmd_e        cmd;
    keys_t       cur;
    keys_t       prev;
    bit          typed;
    key_result_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  krnkq_req_if req_bus ();
  krnkq_rsp_if rsp_bus ();

  keyboard_report_new_key_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #10 clk_i = ~clk_i;

  // model of the key ring
  code_t key_store [RingSize];
  idx_t  wr_ptr;
  idx_t  rd_ptr;

  key_result_t pending_results [$];
  stim_row_t   stim_table [$];

  // typed expectation travels with the request payload
  bit          req_typed;
  key_result_t req_want;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned stall_cycles;
  int unsigned fail_count;

  function automatic idx_t ring_next(idx_t i);
    return (i == idx_t'(RingSize - 1)) ? idx_t'(0) : idx_t'(i + 1'b1);
  endfunction

  function automatic key_result_t step_key_queue(cmd_e cmd, keys_t cur, keys_t prev);
    key_result_t res;
    int          errors;
    code_t       code;
    bit          seen;
    res = '{report_ok: 1'b1, key_valid: 1'b0, key_out: NoKey};
    if (cmd == CmdPop) begin
      if (rd_ptr != wr_ptr) begin
        res.key_valid = 1'b1;
        res.key_out   = key_store[rd_ptr];
        rd_ptr        = ring_next(rd_ptr);
      end
      return res;
    end
    errors = 0;
    for (int s = 0; s < KeySlots; s++) begin
      code = cur[8*s +: 8];
      if (code > LastErrorCode) begin
        seen = 1'b0;
        for (int p = 0; p < KeySlots; p++) begin
          if (prev[8*p +: 8] == code) seen = 1'b1;
        end
        // one entry stays empty, so a push onto a full ring is dropped
        if (!seen && ring_next(wr_ptr) != rd_ptr) begin
          key_store[wr_ptr] = code;
          wr_ptr            = ring_next(wr_ptr);
        end
      end else if (code != NoKey) begin
        errors++;
      end
    end
    res.report_ok = (errors < KeySlots);
    return res;
  endfunction

  // request capture, response check and watchdog in one process, so an
  // expectation is always queued before its response can be compared
  always @(posedge clk_i) begin
    key_result_t predicted;
    key_result_t want;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        predicted = step_key_queue(cmd_e'(req_bus.command), req_bus.report_keys,
                                   req_bus.previous_keys);
        pending_results.push_back(req_typed ? req_want : predicted);
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result ok=%0b valid=%0b key=%02h", $time,
                   rsp_bus.report_ok, rsp_bus.key_valid, rsp_bus.key_out);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_bus.report_ok !== want.report_ok) begin
            $display("%0t: report_ok expected %0b actual %0b", $time,
                     want.report_ok, rsp_bus.report_ok);
            fail_count++;
          end
          if (rsp_bus.key_valid !== want.key_valid) begin
            $display("%0t: key_valid expected %0b actual %0b", $time,
                     want.key_valid, rsp_bus.key_valid);
            fail_count++;
          end
          if (rsp_bus.key_out !== want.key_out) begin
            $display("%0t: key_out expected %02h actual %02h", $time,
                     want.key_out, rsp_bus.key_out);
            fail_count++;
          end
        end
      end
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic send_item(input cmd_e cmd, input keys_t cur, input keys_t prev,
                           input bit typed, input key_result_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid         <= 1'b1;
    req_bus.command       <= cmd;
    req_bus.report_keys   <= cur;
    req_bus.previous_keys <= prev;
    req_typed             <= typed;
    req_want              <= want;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  task automatic add_row(input cmd_e cmd, input keys_t cur, input keys_t prev,
                         input bit typed, input key_result_t want);
    stim_table.push_back('{cmd: cmd, cur: cur, prev: prev, typed: typed, want: want});
  endtask

  initial begin
    keys_t       cur;
    keys_t       prev;
    keys_t       last_keys;
    code_t       code;
    int unsigned pick;
    int unsigned pop_pct;
    key_result_t empty_pop;
    key_result_t report_pass;
    key_result_t report_bad;

    rst_ni                = 1'b0;
    req_bus.valid         <= 1'b0;
    req_bus.command       <= CmdReport;
    req_bus.report_keys   <= '0;
    req_bus.previous_keys <= '0;
    req_typed             <= 1'b0;
    req_want              <= '0;
    wr_ptr       = '0;
    rd_ptr       = '0;
    stall_cycles = 0;
    fail_count   = 0;
    last_keys    = '0;
    pop_pct      = 50;
    src_idle_pct = 31;
    snk_idle_pct = 54;
    empty_pop    = '{report_ok: 1'b1, key_valid: 1'b0, key_out: NoKey};
    report_pass  = '{report_ok: 1'b1, key_valid: 1'b0, key_out: NoKey};
    report_bad   = '{report_ok: 1'b0, key_valid: 1'b0, key_out: NoKey};

    // pop on the empty ring, then error and blank reports, one new key and its pop
    add_row(CmdPop,    '0,               '0,               1'b1, empty_pop);
    add_row(CmdReport, '0,               '0,               1'b1, report_pass);
    add_row(CmdReport, 48'h010203010203, '0,               1'b1, report_bad);
    add_row(CmdReport, 48'h010101010101, 48'hffffffffffff, 1'b1, report_bad);
    add_row(CmdReport, 48'h030303030303, '0,               1'b1, report_bad);
    add_row(CmdReport, 48'h030201030200, '0,               1'b1, report_pass);
    add_row(CmdReport, 48'h030201030204, '0,               1'b1, report_pass);
    add_row(CmdPop,    48'hffffffffffff, 48'hffffffffffff, 1'b0, '0);
    add_row(CmdPop,    '0,               '0,               1'b1, empty_pop);
    // repeated codes, then overfill the ring
    add_row(CmdReport, 48'hffffffffffff, '0,               1'b0, '0);
    add_row(CmdReport, 48'h040506070809, '0,               1'b0, '0);
    for (int i = 0; i < RingSize; i++) add_row(CmdPop, '0, '0, 1'b0, '0);
    // codes already held in the previous report are not pushed
    add_row(CmdReport, 48'h0a0b0c0d0e0f, 48'h0f0e0d0c0b0a, 1'b0, '0);
    add_row(CmdReport, 48'h040506070809, 48'h0000000007ff, 1'b0, '0);
    add_row(CmdReport, 48'hffffffffffff, 48'hffffffffffff, 1'b0, '0);
    add_row(CmdReport, '0,               48'hffffffffffff, 1'b0, '0);
    for (int i = 0; i < 6; i++) add_row(CmdPop, '0, '0, 1'b0, '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      send_item(stim_table[i].cmd, stim_table[i].cur, stim_table[i].prev,
                stim_table[i].typed, stim_table[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 31;
          snk_idle_pct = 54;
        end
        1: begin
          src_idle_pct = 54;
          snk_idle_pct = 31;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        // shift the pop rate now and then so the ring both fills and drains
        if (n % 50 == 0) pop_pct = $urandom_range(75, 25);
        if ($urandom_range(99) < pop_pct) begin
          cur  = keys_t'({$urandom, $urandom});
          prev = keys_t'({$urandom, $urandom});
          send_item(CmdPop, cur, prev, 1'b0, '0);
        end else begin
          pick = $urandom_range(99);
          if (pick < 12) begin
            cur  = keys_t'({$urandom, $urandom});
            prev = keys_t'({$urandom, $urandom});
          end else if (pick < 17) begin
            // keyboard rollover: every slot reports an error code
            prev = last_keys;
            for (int s = 0; s < KeySlots; s++) cur[8*s +: 8] = code_t'($urandom_range(3, 1));
          end else begin
            prev = last_keys;
            for (int s = 0; s < KeySlots; s++) begin
              pick = $urandom_range(99);
              if (pick < 35) begin
                code = last_keys[8*s +: 8];
              end else if (pick < 45 && s > 0) begin
                code = cur[8*$urandom_range(s - 1) +: 8];
              end else if (pick < 75) begin
                code = code_t'($urandom_range(255, 4));
              end else if (pick < 85) begin
                code = code_t'($urandom_range(3, 1));
              end else begin
                code = NoKey;
              end
              cur[8*s +: 8] = code;
            end
          end
          last_keys = cur;
          send_item(CmdReport, cur, prev, 1'b0, '0);
        end
      end
    end
    req_bus.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/krnkq_pkg.sv
src/krnkq_if.sv
src/krnkq_slot_scan.sv
src/krnkq_ring.sv
src/keyboard_report_new_key_queue.sv
test/tb.sv
